@@ hw/rtl/signed_int_to_decimal_ascii_macros.svh @@
// Assertion macros for the signed_int_to_decimal_ascii RTL.
// Needs nothing else; included by the module that asserts, signed_int_to_decimal_ascii.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, skipped during reset.
`define SIDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped during reset.
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/itoa_pkg.sv @@
// Package for signed_int_to_decimal_ascii: widths, ASCII codes, FSM and cell op types.
// No dependencies.
`timescale 1ns / 1ps

package itoa_pkg;

   localparam int ValueWidth = 32;
   localparam int DigitCount = 10;
   localparam int BitCntWidth = $clog2(ValueWidth);
   localparam int LeftWidth = $clog2(DigitCount + 1);

   localparam logic [7:0] CharZero = 8'd48;
   localparam logic [7:0] CharMinus = 8'd45;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_SKIP,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_DABBLE,
      OP_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

endpackage

@@ hw/rtl/itoa_cell.sv @@
// One BCD digit cell of the double-dabble row.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_cell (
   input  logic                  clock,
   input  itoa_pkg::cell_ctrl_type ctrl,
   input  logic                  bit_in,
   input  logic [3:0]            digit_in,
   output logic                  bit_out,
   output logic [3:0]            digit_out
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in_next;
   logic [3:0] adj;

   // add 3 before the shift so the doubled digit carries into the neighbor
   assign adj = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
   assign bit_out = adj[3];
   assign digit_out = digit_ff;

   always_comb begin
      unique case (ctrl.op)
         itoa_pkg::OP_CLEAR:  digit_in_next = 4'd0;
         itoa_pkg::OP_DABBLE: digit_in_next = {adj[2:0], bit_in};
         itoa_pkg::OP_SHIFT:  digit_in_next = digit_in;
         default:             digit_in_next = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii.sv @@
// Accepts one value on start while idle and holds busy, taking no new value, until it is done.
// It shifts the magnitude through a row of ten BCD cells, one bit a cycle; then it
// drops leading zeros and shifts out one character per cycle, MSD first.
// A negative value strobes a minus sign before its first digit.
// Results are strobed once and cannot be stalled. Synchronous reset returns to idle.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic signed [31:0] req_value,
   output logic        rsp_valid,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);

   itoa_pkg::state_type state_ff, state_in;
   logic [itoa_pkg::ValueWidth-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [itoa_pkg::BitCntWidth-1:0] bit_cnt_ff, bit_cnt_in;
   logic [itoa_pkg::LeftWidth-1:0] left_ff, left_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_character_ff, rsp_character_in;
   logic rsp_last_ff, rsp_last_in;

   itoa_pkg::cell_ctrl_type cell_ctrl;
   logic [itoa_pkg::DigitCount:0] chain_bit;
   logic [3:0] chain_digit [itoa_pkg::DigitCount+1];
   logic [3:0] top_digit;
   logic [itoa_pkg::ValueWidth-1:0] raw;

   assign raw = req_value;
   assign chain_bit[0] = mag_ff[itoa_pkg::ValueWidth-1];
   assign chain_digit[0] = 4'd0;
   assign top_digit = chain_digit[itoa_pkg::DigitCount];

   for (genvar i = 0; i < itoa_pkg::DigitCount; i++) begin : g_cell
      itoa_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .bit_in    (chain_bit[i]),
         .digit_in  (chain_digit[i]),
         .bit_out   (chain_bit[i+1]),
         .digit_out (chain_digit[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itoa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      bit_cnt_ff <= bit_cnt_in;
      left_ff <= left_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in = state_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      bit_cnt_in = bit_cnt_ff;
      left_in = left_ff;
      rsp_valid_in = 1'b0;
      rsp_character_in = itoa_pkg::CharZero + {4'd0, top_digit};
      rsp_last_in = 1'b0;
      cell_ctrl.op = itoa_pkg::OP_HOLD;
      unique case (state_ff)
         itoa_pkg::ST_IDLE: begin
            if (start) begin
               neg_in = raw[itoa_pkg::ValueWidth-1];
               mag_in = raw[itoa_pkg::ValueWidth-1] ? ('0 - raw) : raw;
               bit_cnt_in = '0;
               left_in = itoa_pkg::LeftWidth'(itoa_pkg::DigitCount);
               cell_ctrl.op = itoa_pkg::OP_CLEAR;
               state_in = itoa_pkg::ST_CONVERT;
            end
         end
         itoa_pkg::ST_CONVERT: begin
            cell_ctrl.op = itoa_pkg::OP_DABBLE;
            mag_in = {mag_ff[itoa_pkg::ValueWidth-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == itoa_pkg::BitCntWidth'(itoa_pkg::ValueWidth - 1)) begin
               state_in = neg_ff ? itoa_pkg::ST_SIGN : itoa_pkg::ST_SKIP;
            end
         end
         itoa_pkg::ST_SIGN: begin
            rsp_valid_in = 1'b1;
            rsp_character_in = itoa_pkg::CharMinus;
            state_in = itoa_pkg::ST_SKIP;
         end
         itoa_pkg::ST_SKIP: begin
            // drop leading zeros, but keep the units digit
            if (top_digit == 4'd0 && left_ff != itoa_pkg::LeftWidth'(1)) begin
               cell_ctrl.op = itoa_pkg::OP_SHIFT;
               left_in = left_ff - 1'b1;
            end else begin
               state_in = itoa_pkg::ST_EMIT;
            end
         end
         itoa_pkg::ST_EMIT: begin
            cell_ctrl.op = itoa_pkg::OP_SHIFT;
            left_in = left_ff - 1'b1;
            rsp_valid_in = 1'b1;
            rsp_last_in = (left_ff == itoa_pkg::LeftWidth'(1));
            if (left_ff == itoa_pkg::LeftWidth'(1)) begin
               state_in = itoa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itoa_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != itoa_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last = rsp_last_ff;

   `SIDA_ASSERT_NOW(a_last_frees, clock, reset, rsp_valid && rsp_last, !busy, "last beat while busy")
   `SIDA_ASSERT_NOW(a_mid_busy, clock, reset, rsp_valid && !rsp_last, busy, "non-last beat after idle")
   `SIDA_ASSERT_NEXT(a_accept_quiet, clock, reset, start && !busy, busy && !rsp_valid, "beat right after accept")
   `SIDA_ASSERT_NEXT(a_convert_quiet, clock, reset, state_ff == itoa_pkg::ST_CONVERT, !rsp_valid, "beat during conversion")

endmodule
